// ----- rtl/block_cache_clock_replacement_unit_assert.svh -----
// Assertion helpers for the clock replacement unit.
`ifndef BLOCK_CACHE_CLOCK_REPLACEMENT_UNIT_ASSERT_SVH
`define BLOCK_CACHE_CLOCK_REPLACEMENT_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define BCCR_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bccr: same-cycle check failed");

// Next-cycle implication, masked while reset is held.
`define BCCR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bccr: next-cycle check failed");

`endif

// ----- rtl/bccr_pkg.sv -----
`timescale 1ns / 1ps

package bccr_pkg;

    localparam int NUM_SLOTS_DEF        = 16;
    localparam int NUM_FILES_DEF        = 128;
    localparam int BLOCK_INDEX_BITS_DEF = 32;

    // slot count register
    localparam int         CFG_W     = 5;
    localparam logic [4:0] CFG_RESET = 5'd16;

    localparam int OP_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_CLOSE = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_SWEEP,
        ST_VRD,
        ST_FILL,
        ST_SEEK,
        ST_EMIT,
        ST_NONE
    } t_state;

endpackage

// ----- rtl/bccr_ram.sv -----
`timescale 1ns / 1ps

module bccr_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bccr_ctrl.sv -----
`timescale 1ns / 1ps
`include "block_cache_clock_replacement_unit_assert.svh"

module bccr_ctrl
    import bccr_pkg::*;
#(
    parameter int NUM_SLOTS        = NUM_SLOTS_DEF,
    parameter int NUM_FILES        = NUM_FILES_DEF,
    parameter int BLOCK_INDEX_BITS = BLOCK_INDEX_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [$clog2(NUM_SLOTS+1)-1:0]   i_slot_count,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [OP_W-1:0]                  i_opcode,
    input  logic [$clog2(NUM_FILES)-1:0]     i_file_id,
    input  logic [BLOCK_INDEX_BITS-1:0]      i_block_index,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_hit,
    output logic [$clog2(NUM_SLOTS)-1:0]     o_slot,
    output logic                             o_writeback_valid,
    output logic [$clog2(NUM_FILES)-1:0]     o_writeback_file,
    output logic [BLOCK_INDEX_BITS-1:0]      o_writeback_block,
    output logic                             o_last
);

    localparam int SW    = $clog2(NUM_SLOTS);
    localparam int FW    = $clog2(NUM_FILES);
    localparam int BW    = BLOCK_INDEX_BITS;
    localparam int DW    = FW + BW;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int SCW   = $clog2(NUM_SLOTS + 2);
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

    t_state r_state, n_state;
    t_opcode r_op;
    logic [FW-1:0] r_file;
    logic [BW-1:0] r_blk;

    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [NUM_SLOTS-1:0] r_ref,   n_ref;
    logic [NUM_SLOTS-1:0] r_dirty, n_dirty;
    logic [NUM_SLOTS-1:0] r_mask,  n_mask;
    logic [NUM_SLOTS-1:0] r_dmask, n_dmask;
    logic [SW-1:0] r_hand, n_hand;
    logic [SW-1:0] r_idx, n_idx;
    logic [SW-1:0] r_cmp_idx, n_cmp_idx;
    logic r_cmp_vld, n_cmp_vld;
    logic r_issue_done, n_issue_done;
    logic [SW-1:0] r_hit_slot, n_hit_slot;
    logic [SW-1:0] r_victim, n_victim;
    logic [SCW-1:0] r_cnt, n_cnt;

    logic r_out_valid, n_out_valid;
    logic r_o_hit;
    logic [SW-1:0] r_o_slot;
    logic r_o_wbv;
    logic [FW-1:0] r_o_wbf;
    logic [BW-1:0] r_o_wbb;
    logic r_o_last;

    logic w_push;
    logic w_res_hit;
    logic [SW-1:0] w_res_slot;
    logic w_res_wbv;
    logic [FW-1:0] w_res_wbf;
    logic [BW-1:0] w_res_wbb;
    logic w_res_last;

    logic w_accept, w_out_free, w_is_rw;
    logic w_owner_eq, w_tag_hit, w_cnt_ok;
    logic [NUM_SLOTS-1:0] w_mask_now;
    logic [NUM_SLOTS-1:0] w_dmask_rest;
    logic [SW-1:0] w_vnext, w_hand_start;
    logic [FW-1:0] w_rd_owner;
    logic [BW-1:0] w_rd_tag;

    logic w_ram_we;
    logic [SW-1:0] w_ram_raddr;
    logic [DW-1:0] w_ram_rdata;

    bccr_ram #(
        .WIDTH(DW),
        .DEPTH(NUM_SLOTS)
    ) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(r_victim),
        .i_wdata({r_file, r_blk}),
        .i_raddr(w_ram_raddr),
        .o_rdata(w_ram_rdata)
    );

    assign w_rd_owner = w_ram_rdata[DW-1:BW];
    assign w_rd_tag   = w_ram_rdata[BW-1:0];

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_is_rw    = (r_op == OP_READ) || (r_op == OP_WRITE);
    assign w_owner_eq = r_valid[r_cmp_idx] && (w_rd_owner == r_file);
    assign w_tag_hit  = w_owner_eq && (w_rd_tag == r_blk);
    assign w_cnt_ok   = r_cnt <= SCW'(i_slot_count);

    assign w_vnext = ((CNT_W'(r_victim) + CNT_W'(1)) < i_slot_count) ?
                     r_victim + SW'(1) : '0;
    assign w_hand_start = (CNT_W'(r_hand) >= i_slot_count) ? '0 : r_hand;

    always_comb begin
        w_mask_now = r_mask;
        if (r_cmp_vld) begin
            w_mask_now[r_cmp_idx] = w_owner_eq;
        end
        w_dmask_rest = r_dmask;
        w_dmask_rest[r_idx] = 1'b0;
    end

    // read port: slot walk, or the victim held across read and fill
    always_comb begin
        unique case (r_state)
            ST_VRD, ST_FILL: w_ram_raddr = r_victim;
            default:         w_ram_raddr = r_idx;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cmp_vld) begin
                    if (w_is_rw && w_tag_hit) begin
                        n_state = ST_HIT;
                    end else if (r_cmp_idx == LAST_SLOT) begin
                        if (w_is_rw) begin
                            n_state = ST_SWEEP;
                        end else if ((w_mask_now & r_dirty) == '0) begin
                            n_state = ST_NONE;
                        end else begin
                            n_state = ST_SEEK;
                        end
                    end
                end
            end
            ST_HIT, ST_FILL, ST_NONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (!(w_cnt_ok && r_ref[r_victim])) begin
                    n_state = ST_VRD;
                end
            end
            ST_VRD: n_state = ST_FILL;
            ST_SEEK: begin
                if (r_dmask[r_idx]) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = (w_dmask_rest == '0) ? ST_IDLE : ST_SEEK;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and flag updates
    always_comb begin
        n_valid      = r_valid;
        n_ref        = r_ref;
        n_dirty      = r_dirty;
        n_mask       = r_mask;
        n_dmask      = r_dmask;
        n_hand       = r_hand;
        n_idx        = r_idx;
        n_cmp_idx    = r_cmp_idx;
        n_cmp_vld    = r_cmp_vld;
        n_issue_done = r_issue_done;
        n_hit_slot   = r_hit_slot;
        n_victim     = r_victim;
        n_cnt        = r_cnt;
        w_ram_we     = 1'b0;
        w_push       = 1'b0;
        w_res_hit    = 1'b0;
        w_res_slot   = '0;
        w_res_wbv    = 1'b0;
        w_res_wbf    = '0;
        w_res_wbb    = '0;
        w_res_last   = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx        = '0;
                    n_cmp_vld    = 1'b0;
                    n_issue_done = 1'b0;
                    n_mask       = '0;
                end
            end
            ST_SCAN: begin
                n_cmp_vld = !r_issue_done;
                n_cmp_idx = r_idx;
                if (!r_issue_done) begin
                    if (r_idx == LAST_SLOT) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + SW'(1);
                    end
                end
                n_mask     = w_mask_now;
                n_hit_slot = r_cmp_idx;
                n_dmask    = w_mask_now & r_dirty;
                n_victim   = w_hand_start;
                n_cnt      = '0;
                if (r_cmp_vld && (r_cmp_idx == LAST_SLOT)) begin
                    n_idx = '0;
                end
            end
            ST_HIT: begin
                if (w_out_free) begin
                    w_push     = 1'b1;
                    w_res_hit  = 1'b1;
                    w_res_slot = r_hit_slot;
                    n_ref[r_hit_slot] = 1'b1;
                    if (r_op == OP_WRITE) begin
                        n_dirty[r_hit_slot] = 1'b1;
                    end
                end
            end
            ST_SWEEP: begin
                if (w_cnt_ok && r_ref[r_victim]) begin
                    n_ref[r_victim] = 1'b0;
                    n_victim        = w_vnext;
                    n_cnt           = r_cnt + SCW'(1);
                end
            end
            ST_VRD: begin
            end
            ST_FILL: begin
                if (w_out_free) begin
                    w_push     = 1'b1;
                    w_res_slot = r_victim;
                    w_res_wbv  = r_valid[r_victim] && r_dirty[r_victim];
                    if (w_res_wbv) begin
                        w_res_wbf = w_rd_owner;
                        w_res_wbb = w_rd_tag;
                    end
                    w_ram_we          = 1'b1;
                    n_valid[r_victim] = 1'b1;
                    n_ref[r_victim]   = 1'b1;
                    n_dirty[r_victim] = (r_op == OP_WRITE);
                    n_hand            = w_vnext;
                end
            end
            ST_SEEK: begin
                if (!r_dmask[r_idx]) begin
                    n_idx = r_idx + SW'(1);
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_push         = 1'b1;
                    w_res_slot     = r_idx;
                    w_res_wbv      = 1'b1;
                    w_res_wbf      = r_file;
                    w_res_wbb      = w_rd_tag;
                    w_res_last     = (w_dmask_rest == '0);
                    n_dmask        = w_dmask_rest;
                    n_dirty[r_idx] = 1'b0;
                    n_idx          = r_idx + SW'(1);
                    if (w_res_last && (r_op == OP_CLOSE)) begin
                        n_valid = r_valid & ~r_mask;
                        n_ref   = r_ref & ~r_mask;
                        n_dirty = r_dirty & ~r_mask;
                    end
                end
            end
            ST_NONE: begin
                if (w_out_free) begin
                    w_push = 1'b1;
                    if (r_op == OP_CLOSE) begin
                        n_valid = r_valid & ~r_mask;
                        n_ref   = r_ref & ~r_mask;
                        n_dirty = r_dirty & ~r_mask;
                    end
                end
            end
            default: begin
            end
        endcase

        if (w_push) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_ref        <= '0;
            r_dirty      <= '0;
            r_hand       <= '0;
            r_cmp_vld    <= 1'b0;
            r_issue_done <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_ref        <= n_ref;
            r_dirty      <= n_dirty;
            r_hand       <= n_hand;
            r_cmp_vld    <= n_cmp_vld;
            r_issue_done <= n_issue_done;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= t_opcode'(i_opcode);
            r_file <= i_file_id;
            r_blk  <= i_block_index;
        end
        r_mask     <= n_mask;
        r_dmask    <= n_dmask;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_hit_slot <= n_hit_slot;
        r_victim   <= n_victim;
        r_cnt      <= n_cnt;
        if (w_push) begin
            r_o_hit  <= w_res_hit;
            r_o_slot <= w_res_slot;
            r_o_wbv  <= w_res_wbv;
            r_o_wbf  <= w_res_wbf;
            r_o_wbb  <= w_res_wbb;
            r_o_last <= w_res_last;
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_o_hit;
    assign o_slot            = r_o_slot;
    assign o_writeback_valid = r_o_wbv;
    assign o_writeback_file  = r_o_wbf;
    assign o_writeback_block = r_o_wbb;
    assign o_last            = r_o_last;

    // tag RAM is written only at fill, with the read port parked on the same entry
    `BCCR_ASSERT_IMPLIES(a_ram_wr_interlock, i_clk, i_rst_n, w_ram_we, (r_state == ST_FILL) && (w_ram_raddr == r_victim))
    // the final result of a transaction returns the engine to idle
    `BCCR_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, w_push && w_res_last, r_state == ST_IDLE)
    // the sweep never clears more than one full turn
    `BCCR_ASSERT_IMPLIES(a_sweep_bound, i_clk, i_rst_n, r_state == ST_SWEEP, r_cnt <= SCW'(i_slot_count))
    // after a fill the hand points inside the slots in use
    `BCCR_ASSERT_NEXT(a_hand_in_range, i_clk, i_rst_n, w_ram_we, CNT_W'(r_hand) < i_slot_count)

endmodule

// ----- rtl/block_cache_clock_replacement_unit.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Transaction carries
// --------+-----------+-----------------------+------------------------------------------
// input   | in        | i_in_valid/o_in_stall | opcode, file id, block index
// output  | out       | o_out_valid/i_out_stall| hit, slot, writeback valid/file/block, last
// config  | in        | i_cfg_valid/o_cfg_ready| slot count (5 bits)
//
// Order: one transaction at a time. Read/write: the scan stops at a hit; a miss walks
//   every slot, sweeps the hand past referenced slots clearing their bits, then reads
//   the victim and fills it. Flush/close: a scan of every slot, then a seek through the
//   slots up to the last dirty one, one result per block reported, or one if none.
// Reset: synchronous, active low; flags and hand clear at once, tag RAM is not swept.
// Stalls: i_out_stall holds the output register; input reopens after the final result.

module block_cache_clock_replacement_unit
    import bccr_pkg::*;
#(
    parameter int NUM_SLOTS        = NUM_SLOTS_DEF,
    parameter int NUM_FILES        = NUM_FILES_DEF,
    parameter int BLOCK_INDEX_BITS = BLOCK_INDEX_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_W-1:0]             i_cfg_data,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [OP_W-1:0]              i_opcode,
    input  logic [$clog2(NUM_FILES)-1:0] i_file_id,
    input  logic [BLOCK_INDEX_BITS-1:0]  i_block_index,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_hit,
    output logic [$clog2(NUM_SLOTS)-1:0] o_slot,
    output logic                         o_writeback_valid,
    output logic [$clog2(NUM_FILES)-1:0] o_writeback_file,
    output logic [BLOCK_INDEX_BITS-1:0]  o_writeback_block,
    output logic                         o_last
);

    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    logic [CFG_W-1:0] r_slots;
    logic [CFG_W-1:0] n_slots;
    logic [CNT_W-1:0] w_slot_count;

    // register always ready; user must let writes land between transactions; unenforced
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_slots = r_slots;
        if (i_cfg_valid) begin
            n_slots = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= CFG_RESET;
        end else begin
            r_slots <= n_slots;
        end
    end

    // clamp: zero means one slot, anything past the array means all of it
    always_comb begin
        if (r_slots == '0) begin
            w_slot_count = CNT_W'(1);
        end else if (int'(r_slots) > NUM_SLOTS) begin
            w_slot_count = CNT_W'(NUM_SLOTS);
        end else begin
            w_slot_count = CNT_W'(r_slots);
        end
    end

    bccr_ctrl #(
        .NUM_SLOTS       (NUM_SLOTS),
        .NUM_FILES       (NUM_FILES),
        .BLOCK_INDEX_BITS(BLOCK_INDEX_BITS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_slot_count     (w_slot_count),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_file_id        (i_file_id),
        .i_block_index    (i_block_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_hit            (o_hit),
        .o_slot           (o_slot),
        .o_writeback_valid(o_writeback_valid),
        .o_writeback_file (o_writeback_file),
        .o_writeback_block(o_writeback_block),
        .o_last           (o_last)
    );

endmodule

// ----- tb/block_cache_clock_replacement_unit_test.sv -----
`timescale 1ns / 1ps

module block_cache_clock_replacement_unit_test;
    import bccr_pkg::*;

    localparam int SLOTS              = NUM_SLOTS_DEF;
    localparam int FILE_W             = $clog2(NUM_FILES_DEF);
    localparam int SLOT_W             = $clog2(NUM_SLOTS_DEF);
    localparam int BLK_W              = BLOCK_INDEX_BITS_DEF;
    localparam int QUIET_LIMIT        = 3000;   // idle cycles before the run is abandoned
    localparam int TAIL_CYCLES        = 60;     // quiet tail before the summary is printed
    localparam int RANDOM_PER_SETTING = 25;
    localparam int MAX_PRINTED        = 40;

    // one request transaction as queued for the driver
    typedef struct {
        t_opcode           op;
        logic [FILE_W-1:0] file;
        logic [BLK_W-1:0]  blk;
        logic              drain;   // hold back until every result so far has arrived
    } cache_req_t;

    // one result transaction
    typedef struct {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              wb_valid;
        logic [FILE_W-1:0] wb_file;
        logic [BLK_W-1:0]  wb_block;
        logic              last;
    } cache_result_t;

    // slot-count settings visited after the directed part; 0 and 31 are out of range
    localparam logic [CFG_W-1:0] SLOT_SETTINGS [8] = '{
        5'd4, 5'd1, 5'd0, 5'd31, 5'd9, 5'd2, 5'd16, 5'd13
    };

    // ---------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ---------------------------------------------------------------------
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data    = CFG_RESET;
    logic              i_in_valid    = 1'b0;
    logic              o_in_stall;
    logic [OP_W-1:0]   i_opcode      = OP_READ;
    logic [FILE_W-1:0] i_file_id     = '0;
    logic [BLK_W-1:0]  i_block_index = '0;
    logic              o_out_valid;
    logic              i_out_stall   = 1'b0;
    logic              o_hit;
    logic [SLOT_W-1:0] o_slot;
    logic              o_writeback_valid;
    logic [FILE_W-1:0] o_writeback_file;
    logic [BLK_W-1:0]  o_writeback_block;
    logic              o_last;

    block_cache_clock_replacement_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_file_id         (i_file_id),
        .i_block_index     (i_block_index),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_hit             (o_hit),
        .o_slot            (o_slot),
        .o_writeback_valid (o_writeback_valid),
        .o_writeback_file  (o_writeback_file),
        .o_writeback_block (o_writeback_block),
        .o_last            (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Shadow copy of the tag store, flags, clock hand and slot count
    // ---------------------------------------------------------------------
    logic [SLOTS-1:0]  line_valid = '0;
    logic [SLOTS-1:0]  line_ref   = '0;
    logic [SLOTS-1:0]  line_dirty = '0;
    logic [FILE_W-1:0] line_owner [SLOTS];
    logic [BLK_W-1:0]  line_tag   [SLOTS];
    int unsigned       hand_pos   = 0;
    logic [CFG_W-1:0]  slot_count = CFG_RESET;

    cache_req_t    pending_reqs [$];       // filled by the stimulus, drained by the driver
    cache_result_t expected_results [$];   // oldest first
    cache_req_t    cur_req;
    logic          req_in_flight = 1'b0;   // driver holds a request not yet taken
    logic          traffic_jitter = 1'b1;  // gaps and stalls enabled for this stretch

    int unsigned errors       = 0;
    int unsigned op_count [4] = '{default: 0};
    int unsigned n_results    = 0;
    int unsigned n_hits       = 0;
    int unsigned n_writebacks = 0;
    int unsigned n_settings   = 1;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Work out the results one request produces and update the shadow state.
    function automatic void predict_request(cache_req_t rq);
        cache_result_t res;
        cache_result_t batch [$];
        int unsigned   n;
        int unsigned   h;
        int unsigned   i;
        logic          found;

        res = '{default: '0};
        // out-of-range counts are clamped to 1..SLOTS
        n = (slot_count == 0) ? 1 : ((slot_count > SLOTS) ? SLOTS : slot_count);
        if (rq.op == OP_READ || rq.op == OP_WRITE) begin
            found = 1'b0;
            for (i = 0; i < SLOTS && !found; i++) begin
                if (line_valid[i] && line_owner[i] == rq.file && line_tag[i] == rq.blk) begin
                    found       = 1'b1;
                    line_ref[i] = 1'b1;
                    if (rq.op == OP_WRITE) line_dirty[i] = 1'b1;
                    res.hit  = 1'b1;
                    res.slot = SLOT_W'(i);
                end
            end
            if (!found) begin
                // a hand parked beyond the active count restarts at slot 0
                h = (hand_pos >= n) ? 0 : hand_pos;
                for (i = 0; i <= n && line_ref[h]; i++) begin
                    line_ref[h] = 1'b0;
                    h = (h + 1 < n) ? h + 1 : 0;
                end
                if (line_valid[h] && line_dirty[h]) begin
                    res.wb_valid = 1'b1;
                    res.wb_file  = line_owner[h];
                    res.wb_block = line_tag[h];
                end
                line_valid[h] = 1'b1;
                line_ref[h]   = 1'b1;
                line_dirty[h] = (rq.op == OP_WRITE);
                line_owner[h] = rq.file;
                line_tag[h]   = rq.blk;
                res.slot      = SLOT_W'(h);
                hand_pos      = (h + 1 < n) ? h + 1 : 0;
            end
            res.last = 1'b1;
            expected_results.push_back(res);
        end else begin
            // flush and close walk every slot, active or not
            for (i = 0; i < SLOTS; i++) begin
                if (line_valid[i] && line_dirty[i] && line_owner[i] == rq.file) begin
                    res          = '{default: '0};
                    res.slot     = SLOT_W'(i);
                    res.wb_valid = 1'b1;
                    res.wb_file  = rq.file;
                    res.wb_block = line_tag[i];
                    batch.push_back(res);
                    line_dirty[i] = 1'b0;
                end
                if (rq.op == OP_CLOSE && line_valid[i] && line_owner[i] == rq.file) begin
                    line_valid[i] = 1'b0;
                    line_ref[i]   = 1'b0;
                    line_dirty[i] = 1'b0;
                end
            end
            if (batch.size() == 0) begin
                res      = '{default: '0};
                res.last = 1'b1;
                batch.push_back(res);
            end else begin
                batch[batch.size() - 1].last = 1'b1;
            end
            foreach (batch[j]) expected_results.push_back(batch[j]);
        end
    endfunction

    // mostly short, now and then long
    function automatic int unsigned pick_length();
        if ($urandom_range(99) < 85) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic int unsigned pick_gap();
        if (!traffic_jitter || $urandom_range(99) < 55) return 0;
        return pick_length();
    endfunction

    // ---------------------------------------------------------------------
    // Request driver: takes from the pending queue, predicts on acceptance
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : request_driver
        logic launch;

        launch = 1'b0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) begin
                // transaction accepted at this edge
                predict_request(cur_req);
                op_count[cur_req.op]++;
                req_in_flight = 1'b0;
                gap_left      = pick_gap();
            end
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].drain || expected_results.size() == 0)) begin
                cur_req       = pending_reqs.pop_front();
                req_in_flight = 1'b1;
                launch        = 1'b1;
            end
            i_in_valid <= launch;
            if (launch) begin
                i_opcode      <= cur_req.op;
                i_file_id     <= cur_req.file;
                i_block_index <= cur_req.blk;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result monitor: compares each accepted result, drives back-pressure
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        cache_result_t got;
        cache_result_t want;
        logic          stall_now;

        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_hit, o_slot, o_writeback_valid, o_writeback_file,
                        o_writeback_block, o_last};
                n_results++;
                if (got.hit) n_hits++;
                if (got.wb_valid) n_writebacks++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              n_results));
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch($sformatf("result %0d: hit %0b, expected %0b",
                                                  n_results, got.hit, want.hit));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("result %0d: slot %0d, expected %0d",
                                                  n_results, got.slot, want.slot));
                    if (got.wb_valid !== want.wb_valid)
                        report_mismatch($sformatf("result %0d: writeback valid %0b, expected %0b",
                                                  n_results, got.wb_valid, want.wb_valid));
                    if (got.wb_file !== want.wb_file)
                        report_mismatch($sformatf("result %0d: writeback file %0d, expected %0d",
                                                  n_results, got.wb_file, want.wb_file));
                    if (got.wb_block !== want.wb_block)
                        report_mismatch($sformatf("result %0d: writeback block %h, expected %h",
                                                  n_results, got.wb_block, want.wb_block));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("result %0d: last %0b, expected %0b",
                                                  n_results, got.last, want.last));
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                stall_now = 1'b1;
            end else if (traffic_jitter && $urandom_range(99) < 20) begin
                stall_left = pick_length() - 1;
                stall_now  = 1'b1;
            end else begin
                stall_now = 1'b0;
            end
            i_out_stall <= stall_now;
        end
    end

    // watchdog: any transaction on any channel resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    task automatic push_req(t_opcode op, logic [FILE_W-1:0] file, logic [BLK_W-1:0] blk,
                            logic drain);
        cache_req_t rq;

        rq.op    = op;
        rq.file  = file;
        rq.blk   = blk;
        rq.drain = drain;
        pending_reqs.push_back(rq);
    endtask

    // returns once every queued request is taken and every result has come back
    task automatic wait_until_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || req_in_flight || expected_results.size() != 0);
    endtask

    // called at a clock edge with the unit idle
    task automatic write_slot_count(logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        slot_count = value;
        n_settings++;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [FILE_W-1:0] file_pool [3];
        cache_req_t        rq;
        int unsigned       r;

        foreach (line_owner[i]) begin
            line_owner[i] = '0;
            line_tag[i]   = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty flush and close, hits, dirty marking, a flush of several dirty
        // blocks, a close, stale entries after close, then a fill that wraps
        push_req(OP_FLUSH, 7'd0,   32'h0000_0000, 1'b0);
        push_req(OP_CLOSE, 7'd127, 32'hFFFF_FFFF, 1'b0);
        push_req(OP_READ,  7'd0,   32'h0000_0000, 1'b0);
        push_req(OP_WRITE, 7'd0,   32'h0000_0000, 1'b0);
        push_req(OP_WRITE, 7'd127, 32'hFFFF_FFFF, 1'b0);
        push_req(OP_READ,  7'd127, 32'hFFFF_FFFF, 1'b0);
        push_req(OP_WRITE, 7'd0,   32'h0000_0001, 1'b0);
        push_req(OP_WRITE, 7'd0,   32'h0000_0002, 1'b0);
        push_req(OP_FLUSH, 7'd0,   32'h5555_5555, 1'b0);
        push_req(OP_WRITE, 7'd0,   32'h0000_0000, 1'b0);
        push_req(OP_CLOSE, 7'd0,   32'hAAAA_AAAA, 1'b0);
        push_req(OP_READ,  7'd0,   32'h0000_0000, 1'b1);  // sender waits for a clean slate
        for (int k = 0; k < 13; k++) push_req(OP_WRITE, 7'd5, BLK_W'(10 + k), 1'b0);
        wait_until_drained();

        // random part: small file and block pools so hits, dirty evictions and
        // multi-block flushes are common, with an odd fully random request
        foreach (SLOT_SETTINGS[p]) begin
            traffic_jitter = (p % 3 != 1);
            write_slot_count(SLOT_SETTINGS[p]);
            foreach (file_pool[f]) file_pool[f] = FILE_W'($urandom_range(NUM_FILES_DEF - 1));
            for (int k = 0; k < RANDOM_PER_SETTING; k++) begin
                r  = $urandom_range(99);
                rq.op = (r < 40) ? OP_READ : (r < 75) ? OP_WRITE : (r < 90) ? OP_FLUSH : OP_CLOSE;
                if ($urandom_range(9) == 0) begin
                    rq.file = FILE_W'($urandom_range(NUM_FILES_DEF - 1));
                    rq.blk  = $urandom;
                end else begin
                    rq.file = file_pool[$urandom_range(2)];
                    rq.blk  = (rq.op == OP_FLUSH || rq.op == OP_CLOSE) ? $urandom
                                                                       : $urandom_range(12);
                end
                rq.drain = ($urandom_range(29) == 0);
                pending_reqs.push_back(rq);
            end
            wait_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d reads, %0d writes, %0d flushes and %0d closes over %0d slot counts.",
                 op_count[OP_READ], op_count[OP_WRITE], op_count[OP_FLUSH],
                 op_count[OP_CLOSE], n_settings);
        $display("Checked %0d results: %0d hits, %0d writebacks; %0d mismatches.",
                 n_results, n_hits, n_writebacks, errors);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
